// ===== rtl/bdrf_pkg.sv =====
`default_nettype none

package bdrf_pkg;

	// default width of byte offsets and counters
	localparam int OFFSET_BITS_DEF = 32;

	// fixed field widths
	localparam int GAP_W = 16;
	localparam int RUN_W = 17;
	localparam int OUT_W = 32;

	localparam logic [GAP_W-1:0] GAP_RESET = 16'd256;

	typedef enum logic {
		REC_REGION  = 1'b0,
		REC_SUMMARY = 1'b1
	} rec_kind_t;

	// one result item
	typedef struct packed {
		rec_kind_t        kind;
		logic [OUT_W-1:0] start_off;
		logic [OUT_W-1:0] end_off;
		logic [OUT_W-1:0] changed;
		logic [OUT_W-1:0] regions;
		logic             is_final;
	} rec_t;

endpackage

`default_nettype wire

// ===== rtl/bdrf_tracker.sv =====
`default_nettype none

module bdrf_tracker #(
	parameter int OFFSET_BITS = bdrf_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [7:0]                  byte_a,
	input  wire logic [7:0]                  byte_b,
	input  wire logic                        last_byte,
	input  wire logic [bdrf_pkg::GAP_W-1:0]  gap_limit,
	output logic      [1:0]                  n_rec,
	output bdrf_pkg::rec_t                   rec0,
	output bdrf_pkg::rec_t                   rec1
);
	import bdrf_pkg::*;

	localparam int W = OFFSET_BITS;

	function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
		return (&v) ? v : v + W'(1);
	endfunction

	logic             in_region_q, in_region_d;
	logic [RUN_W-1:0] equal_run_q, equal_run_d;
	logic [W-1:0]     open_begin_q, open_begin_d;
	logic [W-1:0]     position_q, position_d;
	logic [W-1:0]     changed_q, changed_d;
	logic [W-1:0]     regions_q, regions_d;

	logic             diff;
	logic             close;
	logic             open_at_end;
	logic [RUN_W-1:0] run_inc;
	logic [W-1:0]     end_close;
	rec_t             close_rec, open_rec, summary_rec;

	assign diff      = byte_a != byte_b;
	assign run_inc   = equal_run_q + RUN_W'(1);
	assign close     = !diff && in_region_q && (run_inc > RUN_W'(gap_limit));
	// region ends just after its last differing byte
	assign end_close = position_q - W'(run_inc) + W'(1);

	// per-byte state update
	always_comb begin
		in_region_d  = in_region_q;
		equal_run_d  = equal_run_q;
		open_begin_d = open_begin_q;
		changed_d    = changed_q;
		regions_d    = regions_q;
		position_d   = sat_inc(position_q);
		if (diff) begin
			if (!in_region_q) begin
				open_begin_d = position_q;
				in_region_d  = 1'b1;
				regions_d    = sat_inc(regions_q);
			end
			changed_d   = sat_inc(changed_q);
			equal_run_d = '0;
		end else if (in_region_q) begin
			if (close) begin
				in_region_d = 1'b0;
				equal_run_d = '0;
			end else begin
				equal_run_d = run_inc;
			end
		end
	end

	assign open_at_end = last_byte && in_region_d;

	// candidate records
	always_comb begin
		close_rec.kind      = REC_REGION;
		close_rec.start_off = OUT_W'(open_begin_q);
		close_rec.end_off   = OUT_W'(end_close);
		close_rec.changed   = OUT_W'(changed_d);
		close_rec.regions   = OUT_W'(regions_d);
		close_rec.is_final  = 1'b0;

		open_rec            = close_rec;
		open_rec.start_off  = OUT_W'(open_begin_d);
		open_rec.end_off    = OUT_W'(position_d);

		summary_rec           = open_rec;
		summary_rec.kind      = REC_SUMMARY;
		summary_rec.start_off = '0;
		summary_rec.is_final  = 1'b1;
	end

	assign n_rec = {1'b0, close} + {1'b0, open_at_end} + {1'b0, last_byte};
	assign rec0  = close ? close_rec : (open_at_end ? open_rec : summary_rec);
	assign rec1  = summary_rec;

	// state registers; the last pair returns the stream to its reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_region_q  <= 1'b0;
			equal_run_q  <= '0;
			open_begin_q <= '0;
			position_q   <= '0;
			changed_q    <= '0;
			regions_q    <= '0;
		end else if (step) begin
			if (last_byte) begin
				in_region_q  <= 1'b0;
				equal_run_q  <= '0;
				open_begin_q <= '0;
				position_q   <= '0;
				changed_q    <= '0;
				regions_q    <= '0;
			end else begin
				in_region_q  <= in_region_d;
				equal_run_q  <= equal_run_d;
				open_begin_q <= open_begin_d;
				position_q   <= position_d;
				changed_q    <= changed_d;
				regions_q    <= regions_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/byte_diff_region_finder.sv =====
// An accepted item is registered in the input register (s1); its records are then buffered.
// Throughput: one byte pair per cycle while the output buffer has space; a last pair
//   that yields a region record and the summary fills both buffer entries.
// Rate is set by the output buffer, which takes the records of one pair per cycle.
// Reset (arst_n low, asynchronous) clears the stream state and buffers; gap_limit -> 256.
`default_nettype none

module byte_diff_region_finder #(
	parameter int OFFSET_BITS = bdrf_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_wr_en,
	input  wire logic [bdrf_pkg::GAP_W-1:0]    cfg_wr_data,
	// input items
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    byte_a,
	input  wire logic [7:0]                    byte_b,
	input  wire logic                          last_byte,
	// result items
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               record_kind,
	output logic      [bdrf_pkg::OUT_W-1:0]    region_begin,
	output logic      [bdrf_pkg::OUT_W-1:0]    region_end,
	output logic      [bdrf_pkg::OUT_W-1:0]    changed_total,
	output logic      [bdrf_pkg::OUT_W-1:0]    region_total,
	output logic                               final_record
);
	import bdrf_pkg::*;

	logic [GAP_W-1:0] gap_limit_q;

	logic       valid_s1;
	logic [7:0] byte_a_s1, byte_b_s1;
	logic       last_s1;

	logic [1:0] n_rec;
	rec_t       rec0, rec1;
	logic [1:0] cnt_q;
	rec_t       slot0_q, slot1_q;

	logic       pop;
	logic       space;
	logic       advance;

	// gap limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_RESET;
		end else if (cfg_wr_en) begin
			gap_limit_q <= cfg_wr_data;
		end
	end

	// handshake: an item leaves s1 when the output buffer can take its records
	assign pop      = out_valid && out_ready;
	assign space    = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	assign advance  = valid_s1 && ((n_rec == 2'd0) || space);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_a_s1 <= byte_a;
			byte_b_s1 <= byte_b;
			last_s1   <= last_byte;
		end
	end

	bdrf_tracker #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_a    (byte_a_s1),
		.byte_b    (byte_b_s1),
		.last_byte (last_s1),
		.gap_limit (gap_limit_q),
		.n_rec     (n_rec),
		.rec0      (rec0),
		.rec1      (rec1)
	);

	// two-entry output buffer, head in slot0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (advance && (n_rec != 2'd0)) begin
			cnt_q <= n_rec;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (n_rec != 2'd0)) begin
			slot0_q <= rec0;
			slot1_q <= rec1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	assign out_valid     = cnt_q != 2'd0;
	assign record_kind   = slot0_q.kind;
	assign region_begin  = slot0_q.start_off;
	assign region_end    = slot0_q.end_off;
	assign changed_total = slot0_q.changed;
	assign region_total  = slot0_q.regions;
	assign final_record  = slot0_q.is_final;

`ifndef ASSERT_OFF
	// buffer never holds more than two records
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer overfilled");

	// a second buffered record is always the summary
	a_slot1_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (slot1_q.kind == REC_SUMMARY))
		else $error("second record is not a summary");

	// summary and final flag travel together
	a_final_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (record_kind == final_record))
		else $error("final flag mismatch");

	// after a summary is taken with nothing queued behind, the buffer is empty
	a_summary_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && final_record && (cnt_q == 2'd1) && !advance) |=> (cnt_q == 2'd0))
		else $error("buffer not empty after summary");
`endif

endmodule

`default_nettype wire
